>>> sv/rhdm_pkg.sv
// rhdm_pkg: shared types, constants and modular helpers for the
// rolling hash digit matcher. No dependencies.
`default_nettype none

package rhdm_pkg;

    localparam int POS_WIDTH = 32;   // text positions and window counts
    localparam int PAT_SLOTS = 16;   // nibbles in the pattern register
    localparam int NIB_W     = 4;
    localparam int LEN_W     = 5;
    localparam int HASH_W    = 7;    // holds any residue of a modulus up to 127
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 2;
    localparam int Q_DEPTH   = 4;    // front-to-back command queue

    localparam logic [POS_WIDTH-1:0] POS_MAX = '1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LENGTH  = 2'd1;

    typedef struct packed {
        logic [NIB_W-1:0] text_digit;
        logic             last_digit;
    } t_item;

    typedef struct packed {
        logic                 window_full;
        logic                 hash_equal;
        logic                 is_match;
        logic [POS_WIDTH-1:0] window_start;
        logic                 text_end;
        logic                 found_any;
        logic [POS_WIDTH-1:0] answer_index;
    } t_result;

    // classified digit, front to back
    typedef struct packed {
        logic [NIB_W-1:0]     digit;
        logic                 last;
        logic                 drop;    // oldest digit leaves the window
        logic                 full;    // a full window ends at this digit
        logic [POS_WIDTH-1:0] start;   // window start, zero when not full
        logic [POS_WIDTH-1:0] count;   // full windows so far, zero when not full
    } t_cmd;

    // settled configuration, config unit to front and back
    typedef struct packed {
        logic                                busy;
        logic [LEN_W-1:0]                    m;         // effective length
        logic [HASH_W-1:0]                   hp;        // pattern hash
        logic [PAT_SLOTS-1:0][HASH_W-1:0]    drop;      // (v * RADIX^(m-1)) mod M
        logic [PAT_SLOTS-1:0][NIB_W-1:0]     pat_rev;   // pattern aligned to window
        logic [PAT_SLOTS-1:0]                lane_mask; // window lanes in use
    } t_cfg_view;

    // (a + b) mod m for a, b < m
    function automatic logic [HASH_W-1:0] hash_add(input logic [HASH_W-1:0] a,
                                                    input logic [HASH_W-1:0] b,
                                                    input logic [HASH_W-1:0] modv);
        logic [HASH_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, modv}) begin
            s = s - {1'b0, modv};
        end
        return s[HASH_W-1:0];
    endfunction

    // (a - b) mod m for a, b < m
    function automatic logic [HASH_W-1:0] hash_sub(input logic [HASH_W-1:0] a,
                                                    input logic [HASH_W-1:0] b,
                                                    input logic [HASH_W-1:0] modv);
        logic [HASH_W:0] s;
        s = {1'b0, a} + {1'b0, modv} - {1'b0, b};
        if (s >= {1'b0, modv}) begin
            s = s - {1'b0, modv};
        end
        return s[HASH_W-1:0];
    endfunction

endpackage

`default_nettype wire

>>> sv/rhdm_cfg.sv
// rhdm_cfg: configuration registers and the sequencer that derives the
// pattern hash and the drop-term table. Depends on rhdm_pkg.
`default_nettype none

module rhdm_cfg #(
    parameter int MAX_PATTERN  = 16,
    parameter int HASH_MODULUS = 97,
    parameter int RADIX        = 10
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_cfg_we,
    input  wire logic [rhdm_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [rhdm_pkg::CFG_W-1:0]           i_cfg_data,
    output rhdm_pkg::t_cfg_view                       o_view
);

    localparam int HW = rhdm_pkg::HASH_W;
    localparam int LW = rhdm_pkg::LEN_W;
    localparam int NW = rhdm_pkg::NIB_W;
    localparam int PS = rhdm_pkg::PAT_SLOTS;
    localparam logic [HW-1:0] MOD = HW'(HASH_MODULUS);
    localparam logic [LW-1:0] LEN_CAP = LW'(MAX_PATTERN);

    localparam logic [1:0] SEQ_IDLE = 2'd0;
    localparam logic [1:0] SEQ_HASH = 2'd1;
    localparam logic [1:0] SEQ_DROP = 2'd2;

    logic [HW-1:0] w_mul  [2**HW];
    logic [HW-1:0] w_dmod [2**NW];

    for (genvar k = 0; k < 2**HW; k++) begin : g_mul
        localparam int MV = ((k % HASH_MODULUS) * RADIX) % HASH_MODULUS;
        assign w_mul[k] = HW'(MV);
    end
    for (genvar k = 0; k < 2**NW; k++) begin : g_dmod
        localparam int DV = k % HASH_MODULUS;
        assign w_dmod[k] = HW'(DV);
    end

    logic [rhdm_pkg::CFG_W-1:0] r_pattern;
    logic [LW-1:0]              r_len;
    logic [1:0]                 r_state;
    logic [LW-1:0]              r_step;
    logic [HW-1:0]              r_hp;
    logic [HW-1:0]              r_dm;
    logic [HW-1:0]              r_acc;
    logic [PS-1:0][HW-1:0]      r_drop;

    logic [LW-1:0] w_m;
    logic [NW-1:0] w_nib;

    always_comb begin
        if (r_len == '0) begin
            w_m = LW'(1);
        end else if (r_len > LEN_CAP) begin
            w_m = LEN_CAP;
        end else begin
            w_m = r_len;
        end
        w_nib = r_pattern[r_step[NW-1:0]*NW +: NW];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern <= '0;
            r_len     <= LW'(1);
            r_state   <= SEQ_HASH;
            r_step    <= '0;
            r_hp      <= '0;
            r_dm      <= HW'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                rhdm_pkg::REG_PATTERN: r_pattern <= i_cfg_data;
                rhdm_pkg::REG_LENGTH:  r_len     <= i_cfg_data[LW-1:0];
                default: ;
            endcase
            r_state <= SEQ_HASH;
            r_step  <= '0;
            r_hp    <= '0;
            r_dm    <= HW'(1);
        end else begin
            case (r_state)
                SEQ_HASH: begin
                    r_hp <= rhdm_pkg::hash_add(w_mul[r_hp], w_dmod[w_nib], MOD);
                    if (r_step != '0) begin
                        r_dm <= w_mul[r_dm];
                    end
                    if (r_step == w_m - LW'(1)) begin
                        r_state <= SEQ_DROP;
                        r_step  <= '0;
                    end else begin
                        r_step <= r_step + LW'(1);
                    end
                end
                SEQ_DROP: begin
                    if (r_step == LW'(PS - 1)) begin
                        r_state <= SEQ_IDLE;
                        r_step  <= '0;
                    end else begin
                        r_step <= r_step + LW'(1);
                    end
                end
                SEQ_IDLE: ;
                default: r_state <= SEQ_IDLE;
            endcase
        end
    end

    // drop table: entry v = v * dm mod M, built by accumulation
    always_ff @(posedge i_clk) begin
        if (r_state == SEQ_HASH) begin
            r_acc <= '0;
        end else if (r_state == SEQ_DROP) begin
            r_drop[r_step[NW-1:0]] <= r_acc;
            r_acc                  <= rhdm_pkg::hash_add(r_acc, r_dm, MOD);
        end
    end

    always_comb begin
        o_view.busy = (r_state != SEQ_IDLE);
        o_view.m    = w_m;
        o_view.hp   = r_hp;
        o_view.drop = r_drop;
        for (int i = 0; i < PS; i++) begin
            o_view.lane_mask[i] = (LW'(i) < w_m);
            o_view.pat_rev[i]   = '0;
            if (LW'(i) < w_m) begin
                o_view.pat_rev[i] = r_pattern[(NW'(w_m - LW'(1) - LW'(i)))*NW +: NW];
            end
        end
    end

endmodule

`default_nettype wire

>>> sv/rhdm_front.sv
// rhdm_front: input handshake and digit classification (position count,
// window fill, start and count). Depends on rhdm_pkg.
`default_nettype none

module rhdm_front (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_ready,
    input  wire rhdm_pkg::t_item     i_item,
    input  wire rhdm_pkg::t_cfg_view i_view,
    input  wire logic                i_q_full,
    output logic                     o_push,
    output rhdm_pkg::t_cmd           o_cmd
);

    localparam int PW = rhdm_pkg::POS_WIDTH;

    logic [PW-1:0] r_seen;
    logic [PW-1:0] w_seen_next;
    logic [PW-1:0] w_m;

    always_comb begin
        o_ready     = !i_view.busy && !i_q_full;
        o_push      = i_valid && o_ready;
        w_m         = PW'(i_view.m);
        w_seen_next = (r_seen != rhdm_pkg::POS_MAX) ? r_seen + PW'(1) : r_seen;

        o_cmd.digit = i_item.text_digit;
        o_cmd.last  = i_item.last_digit;
        o_cmd.drop  = (r_seen >= w_m);
        o_cmd.full  = (w_seen_next >= w_m);
        o_cmd.start = '0;
        o_cmd.count = '0;
        if (o_cmd.full) begin
            o_cmd.start = w_seen_next - w_m;
            o_cmd.count = w_seen_next - w_m + PW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= '0;
        end else if (o_push) begin
            r_seen <= i_item.last_digit ? '0 : w_seen_next;
        end
    end

endmodule

`default_nettype wire

>>> sv/rhdm_fifo.sv
// rhdm_fifo: short command queue between front and back.
// Depends on rhdm_pkg.
`default_nettype none

module rhdm_fifo (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire rhdm_pkg::t_cmd  i_cmd,
    output logic                 o_full,
    input  wire logic            i_pop,
    output rhdm_pkg::t_cmd       o_cmd,
    output logic                 o_empty
);

    localparam int DEPTH = rhdm_pkg::Q_DEPTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    rhdm_pkg::t_cmd r_mem [DEPTH];
    logic [AW-1:0]  r_wr;
    logic [AW-1:0]  r_rd;
    logic [CW-1:0]  r_cnt;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + CW'(1);
                2'b01:   r_cnt <= r_cnt - CW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

>>> sv/rhdm_back.sv
// rhdm_back: window store, rolling hash, digit confirm, first-match latch
// and the output register. Depends on rhdm_pkg.
`default_nettype none

module rhdm_back #(
    parameter int MAX_PATTERN  = 16,
    parameter int HASH_MODULUS = 97,
    parameter int RADIX        = 10
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire rhdm_pkg::t_cfg_view i_view,
    input  wire rhdm_pkg::t_cmd      i_cmd,
    input  wire logic                i_empty,
    output logic                     o_pop,
    output logic                     o_valid,
    input  wire logic                i_ready,
    output rhdm_pkg::t_result        o_result
);

    localparam int HW = rhdm_pkg::HASH_W;
    localparam int LW = rhdm_pkg::LEN_W;
    localparam int NW = rhdm_pkg::NIB_W;
    localparam int PW = rhdm_pkg::POS_WIDTH;
    localparam logic [HW-1:0] MOD = HW'(HASH_MODULUS);

    logic [HW-1:0] w_mul  [2**HW];
    logic [HW-1:0] w_dmod [2**NW];

    for (genvar k = 0; k < 2**HW; k++) begin : g_mul
        localparam int MV = ((k % HASH_MODULUS) * RADIX) % HASH_MODULUS;
        assign w_mul[k] = HW'(MV);
    end
    for (genvar k = 0; k < 2**NW; k++) begin : g_dmod
        localparam int DV = k % HASH_MODULUS;
        assign w_dmod[k] = HW'(DV);
    end

    logic [NW-1:0]      r_win [MAX_PATTERN];
    logic [HW-1:0]      r_hash;
    logic               r_found;
    logic [PW-1:0]      r_first;
    rhdm_pkg::t_result  r_out;
    logic               r_out_valid;

    logic [NW-1:0]      w_win [MAX_PATTERN];
    logic [NW-1:0]      w_old;
    logic [HW-1:0]      w_h1;
    logic [HW-1:0]      w_h2;
    logic               w_all_eq;
    logic               w_heq;
    logic               w_mat;
    logic               w_found;
    logic [PW-1:0]      w_first;
    rhdm_pkg::t_result  w_res;

    assign o_pop    = !i_empty && (!r_out_valid || i_ready);
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    always_comb begin
        // oldest digit of the previous window
        w_old = '0;
        for (int i = 0; i < MAX_PATTERN; i++) begin
            if (LW'(i) == i_view.m - LW'(1)) begin
                w_old = r_win[i];
            end
        end
        w_h1 = i_cmd.drop ? rhdm_pkg::hash_sub(r_hash, i_view.drop[w_old], MOD) : r_hash;
        w_h2 = rhdm_pkg::hash_add(w_mul[w_h1], w_dmod[i_cmd.digit], MOD);

        w_win[0] = i_cmd.digit;
        for (int i = 1; i < MAX_PATTERN; i++) begin
            w_win[i] = r_win[i-1];
        end

        w_all_eq = 1'b1;
        for (int i = 0; i < MAX_PATTERN; i++) begin
            if (i_view.lane_mask[i] && (w_win[i] != i_view.pat_rev[i])) begin
                w_all_eq = 1'b0;
            end
        end

        w_heq   = i_cmd.full && (w_h2 == i_view.hp);
        w_mat   = w_heq && w_all_eq;
        w_found = r_found || w_mat;
        w_first = r_found ? r_first : i_cmd.start;

        w_res.window_full  = i_cmd.full;
        w_res.hash_equal   = w_heq;
        w_res.is_match     = w_mat;
        w_res.window_start = i_cmd.start;
        w_res.text_end     = i_cmd.last;
        w_res.found_any    = w_found;
        w_res.answer_index = '0;
        if (i_cmd.last) begin
            w_res.answer_index = w_found ? w_first : i_cmd.count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out <= w_res;
            for (int i = 0; i < MAX_PATTERN; i++) begin
                r_win[i] <= w_win[i];
            end
            if (w_mat && !r_found) begin
                r_first <= i_cmd.start;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash      <= '0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_out_valid <= 1'b1;
                r_hash      <= i_cmd.last ? '0 : w_h2;
                r_found     <= i_cmd.last ? 1'b0 : w_found;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

>>> sv/rolling_hash_digit_matcher.sv
// rolling_hash_digit_matcher: top level, config unit + front + queue + back.
// Depends on rhdm_pkg, rhdm_cfg, rhdm_front, rhdm_fifo, rhdm_back.
`default_nettype none

// Karp-Rabin matcher over a stream of decimal digits. Each transfer on the
// input carries one text digit; each produces exactly one result transfer
// with the window flags, the window start and, on the last digit of a text,
// the first match start (or the number of full windows if nothing matched),
// after which text state clears. Sustained rate is one digit per cycle while
// results are accepted and no recompute runs; each result passes through
// the command queue and the output register before valid rises. The front
// classifies digits (position count, window fill), a four-entry command
// queue decouples it from the back, which holds the window store, the
// rolling hash modulo HASH_MODULUS and the output register, so a stalled
// output does not stop input until the queue fills. After reset and after
// every config write, a sequencer precomputes the pattern hash and the
// table of drop terms, stepping through the m effective pattern digits and
// then all drop-table entries; input ready stays low until done. Config writes take
// effect at once and need no handshake; write only with no transfer in flight.
module rolling_hash_digit_matcher #(
    parameter int MAX_PATTERN  = 16,   // 1..16
    parameter int HASH_MODULUS = 97,   // 2..127
    parameter int RADIX        = 10    // 2..10
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_valid,
    output logic                                  o_ready,
    input  wire rhdm_pkg::t_item                  i_item,
    output logic                                  o_valid,
    input  wire logic                             i_ready,
    output rhdm_pkg::t_result                     o_result,
    input  wire logic                             i_cfg_we,
    input  wire logic [rhdm_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [rhdm_pkg::CFG_W-1:0]       i_cfg_data
);

    rhdm_pkg::t_cfg_view w_view;
    rhdm_pkg::t_cmd      w_push_cmd;
    rhdm_pkg::t_cmd      w_head_cmd;
    logic                w_push;
    logic                w_pop;
    logic                w_q_full;
    logic                w_q_empty;

    // pattern registers and derived hash terms
    rhdm_cfg #(
        .MAX_PATTERN  (MAX_PATTERN),
        .HASH_MODULUS (HASH_MODULUS),
        .RADIX        (RADIX)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_view      (w_view)
    );

    // input transfer and classification
    rhdm_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_item   (i_item),
        .i_view   (w_view),
        .i_q_full (w_q_full),
        .o_push   (w_push),
        .o_cmd    (w_push_cmd)
    );

    rhdm_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .o_full  (w_q_full),
        .i_pop   (w_pop),
        .o_cmd   (w_head_cmd),
        .o_empty (w_q_empty)
    );

    // hash update, confirm, first-match latch, result register
    rhdm_back #(
        .MAX_PATTERN  (MAX_PATTERN),
        .HASH_MODULUS (HASH_MODULUS),
        .RADIX        (RADIX)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_view   (w_view),
        .i_cmd    (w_head_cmd),
        .i_empty  (w_q_empty),
        .o_pop    (w_pop),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_result (o_result)
    );

    // a confirmed match implies equal hashes and a latched first match
    a_match_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.is_match) |-> (o_result.hash_equal && o_result.found_any))
        else $error("match without hash equality or latch");

    // answer field only carries data at text end
    a_answer_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_result.text_end) |-> (o_result.answer_index == '0))
        else $error("answer outside text end");

    // no window: no start and no hash hit
    a_no_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_result.window_full)
            |-> (o_result.window_start == '0 && !o_result.hash_equal))
        else $error("window fields set without full window");

    // a config write blocks input while the hash terms are rebuilt
    a_cfg_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> !o_ready)
        else $error("input accepted during recompute");

endmodule

`default_nettype wire
